@@ rtl/fpa_pkg.sv @@
// fpa_pkg: constants, payload and control types for the frame pixel averager
// no dependencies; imported by every module of the block
`default_nettype none
package fpa_pkg;

	localparam int MAX_PIXELS  = 1024;
	localparam int MAX_WINDOW  = 64;
	localparam int SAMPLE_BITS = 16;

	localparam int POS_W   = $clog2(MAX_PIXELS);
	localparam int SLOT_W  = $clog2(MAX_WINDOW);
	localparam int HIST_AW = POS_W + SLOT_W;

	localparam int SMP_W   = 16;
	localparam int ACC_W   = 24;
	localparam int N_W     = 7;
	localparam int BASE_W  = 26;
	localparam int P_W     = 25;
	localparam int ALPHA_W = 25;
	localparam int FRAC_W  = 24;

	localparam int DVD_W  = 33;
	localparam int DVS_W  = 26;
	localparam int STEP_W = 6;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int RIDX_W  = 3;

	localparam logic [P_W-1:0]   ONE_Q24 = P_W'(1) << FRAC_W;
	localparam logic [ACC_W-1:0] MASK24  = '1;

	localparam logic [N_W-1:0] RESET_N     = N_W'(50);
	localparam logic [BASE_W-1:0] RESET_B  = BASE_W'(17116135);
	localparam logic [P_W-1:0] RESET_INV_B = P_W'(16445002);

	localparam logic [STEP_W-1:0] ALPHA_STEPS = STEP_W'(FRAC_W);
	localparam logic [STEP_W-1:0] MEAN_STEPS  = STEP_W'(DVD_W);

	// register indexes
	localparam logic [RIDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [RIDX_W-1:0] REG_MODE   = 3'd1;
	localparam logic [RIDX_W-1:0] REG_WINDOW = 3'd2;
	localparam logic [RIDX_W-1:0] REG_BASE   = 3'd3;
	localparam logic [RIDX_W-1:0] REG_INV_B  = 3'd4;

	typedef struct packed {
		logic [SMP_W-1:0] sample;
		logic             frame_end;
	} pix_t;

	typedef struct packed {
		logic [ACC_W-1:0] averaged;
		logic             frame_end_res;
		logic [N_W-1:0]   frames_in_average;
	} avg_t;

	typedef struct packed {
		logic              enable;
		logic              mode;
		logic [N_W-1:0]    window_frames;
		logic [BASE_W-1:0] base_q24;
		logic [P_W-1:0]    inv_base_q24;
		logic              restart;
	} cfg_t;

	typedef struct packed {
		logic               rd;
		logic               acc_we;
		logic               hist_we;
		logic [POS_W-1:0]   acc_addr;
		logic [HIST_AW-1:0] hist_addr;
		logic [ACC_W-1:0]   acc_wdata;
		logic [SMP_W-1:0]   hist_wdata;
	} store_req_t;

	typedef struct packed {
		logic              start;
		logic [DVS_W-1:0]  preload;
		logic [DVD_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALPHA,
		S_READ,
		S_CALC,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

@@ rtl/fpa_regs.sv @@
// fpa_regs: apb register file for the averager settings
// depends on fpa_pkg; flags a restart on enable or on any changed setting
`default_nettype none
module fpa_regs
	import fpa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	logic              enable_q;
	logic              mode_q;
	logic [N_W-1:0]    window_q;
	logic [BASE_W-1:0] base_q;
	logic [P_W-1:0]    inv_b_q;
	logic              wr;
	logic              restart;
	logic [RIDX_W-1:0] idx;

	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[PADDR_W-1:2];
	assign pready = 1'b1;

	always_comb begin
		restart = 1'b0;
		if (wr) begin
			unique case (idx)
				REG_ENABLE: restart = pwdata[0];
				REG_MODE:   restart = (mode_q != pwdata[0]);
				REG_WINDOW: restart = (window_q != pwdata[N_W-1:0]);
				REG_BASE:   restart = (base_q != pwdata[BASE_W-1:0]);
				REG_INV_B:  restart = (inv_b_q != pwdata[P_W-1:0]);
				default:    restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			mode_q   <= 1'b1;
			window_q <= RESET_N;
			base_q   <= RESET_B;
			inv_b_q  <= RESET_INV_B;
		end else if (wr) begin
			unique case (idx)
				REG_ENABLE: enable_q <= pwdata[0];
				REG_MODE:   mode_q   <= pwdata[0];
				REG_WINDOW: window_q <= pwdata[N_W-1:0];
				REG_BASE:   base_q   <= pwdata[BASE_W-1:0];
				REG_INV_B:  inv_b_q  <= pwdata[P_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ENABLE: prdata = PDATA_W'(enable_q);
			REG_MODE:   prdata = PDATA_W'(mode_q);
			REG_WINDOW: prdata = PDATA_W'(window_q);
			REG_BASE:   prdata = PDATA_W'(base_q);
			REG_INV_B:  prdata = PDATA_W'(inv_b_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg = '{enable: enable_q, mode: mode_q, window_frames: window_q,
		base_q24: base_q, inv_base_q24: inv_b_q, restart: restart};

endmodule
`default_nettype wire

@@ rtl/fpa_div.sv @@
// fpa_div: restoring divider, one quotient bit per cycle
// depends on fpa_pkg; shared by the blend weight and the window mean
`default_nettype none
module fpa_div
	import fpa_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  div_req_t              req,
	output logic                  done,
	output logic      [DVD_W-1:0] quo
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W:0]    rem2;
	logic              ge;
	logic [DVS_W:0]    rem_nxt;

	assign rem2    = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = rem2 >= {1'b0, dvs_q};
	assign rem_nxt = ge ? rem2 - {1'b0, dvs_q} : rem2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.preload;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nxt[DVS_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

@@ rtl/fpa_store.sv @@
// fpa_store: per-pixel accumulator memory and frame history memory
// depends on fpa_pkg; registered reads, contents not cleared
`default_nettype none
module fpa_store
	import fpa_pkg::*;
(
	input  wire logic             clk,
	input  store_req_t            req,
	output logic      [ACC_W-1:0] acc_rdata,
	output logic      [SMP_W-1:0] hist_rdata
);

	logic [ACC_W-1:0] acc_mem  [MAX_PIXELS];
	logic [SMP_W-1:0] hist_mem [MAX_PIXELS*MAX_WINDOW];
	logic [ACC_W-1:0] acc_rd_q;
	logic [SMP_W-1:0] hist_rd_q;

	always_ff @(posedge clk) begin
		if (req.acc_we) begin
			acc_mem[req.acc_addr] <= req.acc_wdata;
		end
		if (req.rd) begin
			acc_rd_q <= acc_mem[req.acc_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.hist_we) begin
			hist_mem[req.hist_addr] <= req.hist_wdata;
		end
		if (req.rd) begin
			hist_rd_q <= hist_mem[req.hist_addr];
		end
	end

	assign acc_rdata  = acc_rd_q;
	assign hist_rdata = hist_rd_q;

endmodule
`default_nettype wire

@@ rtl/frame_pixel_averager_core.sv @@
// from accept to result: pass-through goes idle, read, done; exponential adds calc and mul
// (a restart frame skips mul); window mean adds calc and the divider. the first pixel of a
// blended exponential frame waits in alpha for the weight divide. one pixel in flight: next
// transfer taken in the cycle after the result is loaded; a held result stalls the core.
// reset clears control and settings; the memories are not cleared and need no sweep.
// frame_pixel_averager_core: top level; depends on fpa_pkg, fpa_regs, fpa_div, fpa_store
`default_nettype none
module frame_pixel_averager_core
	import fpa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               pix_valid,
	output logic                    pix_ready,
	input  pix_t                    pix_data,
	output logic                    avg_valid,
	input  wire logic               avg_ready,
	output avg_t                    avg_data
);

	cfg_t       cfg;
	store_req_t sreq;
	div_req_t   dreq;
	logic       div_done;
	logic [DVD_W-1:0] quo;
	logic [ACC_W-1:0] acc_rdata;
	logic [SMP_W-1:0] hist_rdata;

	state_t state_q, state_nxt;

	logic              out_valid_q;
	avg_t              out_q;
	logic [SMP_W-1:0]  v_q;
	logic              fe_q;
	logic [ACC_W-1:0]  avg_q;
	logic [POS_W-1:0]  pos_q;
	logic              past_end_q;
	logic              fr_on_q, fr_mode_q, fr_restart_q;
	logic [N_W-1:0]    fr_n_q;
	logic [ALPHA_W-1:0] fr_alpha_q;
	logic [N_W-1:0]    held_q;
	logic [SLOT_W-1:0] oldest_q;
	logic [N_W-1:0]    ecnt_q;
	logic [P_W-1:0]    p_q;
	logic              restart_pending_q;
	logic [2*ACC_W:0]  prod_s1;
	logic [ACC_W-1:0]  r_s1;
	logic              neg_s1;

	logic accept, frame_start, need_alpha, trivial, use_mem, out_go;
	logic [N_W-1:0]    n_clamp;
	logic [P_W-1:0]    num;
	logic [BASE_W-1:0] den;
	logic [ACC_W-1:0]  v8;
	logic [N_W-1:0]    h;
	logic              full;
	logic [SLOT_W-1:0] slot;
	logic [ACC_W-1:0]  old_eff;
	logic [SMP_W-1:0]  drop;
	logic [ACC_W:0]    tot, sumr;
	logic [ACC_W-1:0]  sum;
	logic [N_W-1:0]    divv;
	logic [DVD_W-1:0]  dividend;
	logic [N_W-1:0]    ce, ce1, ecount, count;
	logic [ACC_W-1:0]  diff;
	logic              neg;
	logic [ACC_W:0]    mag;
	logic [ACC_W-1:0]  res;
	logic [2*P_W:0]    pm;
	logic [P_W:0]      np;
	logic [P_W-1:0]    np_sat;
	logic [N_W-1:0]    ho;
	logic [SLOT_W-1:0] oo;
	logic [N_W-1:0]    oo1;

	fpa_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	fpa_div u_div (
		.clk, .arst_n, .req(dreq), .done(div_done), .quo
	);

	fpa_store u_store (
		.clk, .req(sreq), .acc_rdata, .hist_rdata
	);

	assign accept      = pix_valid & pix_ready;
	assign frame_start = (pos_q == '0) && !past_end_q;
	assign n_clamp     = (cfg.window_frames == '0) ? N_W'(1) :
		((cfg.window_frames > N_W'(MAX_WINDOW)) ? N_W'(MAX_WINDOW) : cfg.window_frames);

	assign num     = (p_q >= ONE_Q24) ? '0 : ONE_Q24 - p_q;
	assign den     = (cfg.base_q24 > {1'b0, p_q}) ? cfg.base_q24 - {1'b0, p_q} : '0;
	assign trivial = (den == '0) || ({1'b0, num} >= den);
	assign need_alpha = frame_start && cfg.enable && cfg.mode && !restart_pending_q;

	assign v8      = {v_q, 8'b0};
	assign use_mem = fr_on_q && !past_end_q;

	// window bookkeeping
	assign h        = fr_restart_q ? '0 : held_q;
	assign full     = h >= fr_n_q;
	assign slot     = full ? oldest_q : h[SLOT_W-1:0];
	assign old_eff  = fr_restart_q ? '0 : acc_rdata;
	assign drop     = full ? hist_rdata : '0;
	assign tot      = {1'b0, old_eff} + (ACC_W+1)'(v_q);
	assign sumr     = (tot >= (ACC_W+1)'(drop)) ? tot - (ACC_W+1)'(drop) : '0;
	assign sum      = sumr[ACC_W] ? MASK24 : sumr[ACC_W-1:0];
	assign divv     = full ? fr_n_q : h + N_W'(1);
	assign dividend = {1'b0, sum, 8'b0} + DVD_W'(divv >> 1);

	// exponential bookkeeping
	assign ce     = fr_restart_q ? '0 : ecnt_q;
	assign ce1    = ce + N_W'(1);
	assign ecount = (ce1 == fr_n_q) ? '0 : ce1;
	assign count  = !fr_on_q ? '0 : (fr_mode_q ? ecount : divv);

	assign neg  = v8 < acc_rdata;
	assign diff = neg ? acc_rdata - v8 : v8 - acc_rdata;
	assign mag  = (ACC_W+1)'((prod_s1 + (2*ACC_W+1)'(1 << (FRAC_W-1))) >> FRAC_W);
	assign res  = neg_s1 ? r_s1 - mag[ACC_W-1:0] : r_s1 + mag[ACC_W-1:0];

	assign pm     = (2*P_W+1)'(p_q * cfg.inv_base_q24) + (2*P_W+1)'(1 << (FRAC_W-1));
	assign np     = pm[FRAC_W +: P_W+1];
	assign np_sat = np[P_W] ? '1 : np[P_W-1:0];

	assign ho  = fr_restart_q ? '0 : held_q;
	assign oo  = fr_restart_q ? '0 : oldest_q;
	assign oo1 = N_W'(oo) + N_W'(1);

	assign out_go = !out_valid_q || avg_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:  if (accept) state_nxt = (need_alpha && !trivial) ? S_ALPHA : S_READ;
			S_ALPHA: if (div_done) state_nxt = S_READ;
			S_READ:  state_nxt = use_mem ? S_CALC : S_DONE;
			S_CALC:  state_nxt = !fr_mode_q ? S_DIV : (fr_restart_q ? S_DONE : S_MUL);
			S_MUL:   state_nxt = S_DONE;
			S_DIV:   if (div_done) state_nxt = S_DONE;
			S_DONE:  if (out_go) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		pix_ready       = (state_q == S_IDLE);
		sreq            = '0;
		sreq.acc_addr   = pos_q;
		sreq.hist_addr  = {slot, pos_q};
		sreq.hist_wdata = v_q;
		sreq.acc_wdata  = v8;
		dreq            = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && need_alpha && !trivial) begin
					dreq.start   = 1'b1;
					dreq.preload = DVS_W'(num);
					dreq.divisor = den;
					dreq.steps   = ALPHA_STEPS;
				end
			end
			S_READ: sreq.rd = use_mem;
			S_CALC: begin
				if (!fr_mode_q) begin
					sreq.acc_we    = 1'b1;
					sreq.hist_we   = 1'b1;
					sreq.acc_wdata = sum;
					dreq.start     = 1'b1;
					dreq.dividend  = dividend;
					dreq.divisor   = DVS_W'(divv);
					dreq.steps     = MEAN_STEPS;
				end else if (fr_restart_q) begin
					sreq.acc_we = 1'b1;
				end
			end
			S_MUL: begin
				sreq.acc_we    = 1'b1;
				sreq.acc_wdata = res;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_IDLE;
			out_valid_q       <= 1'b0;
			pos_q             <= '0;
			past_end_q        <= 1'b0;
			fr_on_q           <= 1'b0;
			fr_mode_q         <= 1'b0;
			fr_restart_q      <= 1'b0;
			fr_n_q            <= N_W'(1);
			fr_alpha_q        <= '0;
			held_q            <= '0;
			oldest_q          <= '0;
			ecnt_q            <= '0;
			p_q               <= ONE_Q24;
			restart_pending_q <= 1'b1;
		end else begin
			state_q <= state_nxt;
			if (avg_ready) out_valid_q <= 1'b0;
			if (cfg.restart) restart_pending_q <= 1'b1;
			if (state_q == S_IDLE && accept && frame_start) begin
				fr_on_q <= cfg.enable;
				if (cfg.enable) begin
					fr_mode_q         <= cfg.mode;
					fr_n_q            <= n_clamp;
					fr_restart_q      <= restart_pending_q;
					restart_pending_q <= 1'b0;
					if (need_alpha && trivial) fr_alpha_q <= ALPHA_W'(ONE_Q24);
				end
			end
			if (state_q == S_ALPHA && div_done) begin
				fr_alpha_q <= {1'b0, quo[FRAC_W-1:0]};
			end
			if (state_q == S_DONE && out_go) begin
				out_valid_q <= 1'b1;
				if (fe_q) begin
					pos_q      <= '0;
					past_end_q <= 1'b0;
					if (fr_on_q) begin
						if (!fr_mode_q) begin
							if (ho < fr_n_q) begin
								held_q   <= ho + N_W'(1);
								oldest_q <= oo;
							end else begin
								held_q   <= ho;
								oldest_q <= (oo1 == fr_n_q) ? '0 : oo1[SLOT_W-1:0];
							end
						end else begin
							ecnt_q <= ecount;
							p_q    <= fr_restart_q ? cfg.inv_base_q24 : np_sat;
						end
					end
				end else if (!past_end_q) begin
					pos_q <= pos_q + POS_W'(1);
					if (pos_q == POS_W'(MAX_PIXELS - 1)) past_end_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q  <= SMP_W'(pix_data.sample[SAMPLE_BITS-1:0]);
			fe_q <= pix_data.frame_end;
		end
		if (state_q == S_READ && !use_mem) avg_q <= v8;
		if (state_q == S_CALC && fr_mode_q) begin
			if (fr_restart_q) avg_q <= v8;
			prod_s1 <= (2*ACC_W+1)'(diff * fr_alpha_q);
			r_s1    <= acc_rdata;
			neg_s1  <= neg;
		end
		if (state_q == S_MUL) avg_q <= res;
		if (state_q == S_DIV && div_done) begin
			avg_q <= (quo > DVD_W'(MASK24)) ? MASK24 : quo[ACC_W-1:0];
		end
		if (state_q == S_DONE && out_go) begin
			out_q <= '{averaged: avg_q, frame_end_res: fe_q, frames_in_average: count};
		end
	end

	assign avg_valid = out_valid_q;
	assign avg_data  = out_q;

endmodule
`default_nettype wire

@@ rtl/fpa_checker.sv @@
// fpa_checker: port-level checks on the averager top level
// depends on fpa_pkg; bound to frame_pixel_averager_core
`default_nettype none
module fpa_checker
	import fpa_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               pready,
	input wire logic               pix_valid,
	input wire logic               pix_ready,
	input wire logic               avg_valid,
	input wire logic               avg_ready,
	input avg_t                    avg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		avg_valid && !avg_ready |=> avg_valid && $stable(avg_data))
		else $error("result changed before transfer");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> !pix_ready)
		else $error("second pixel taken while one in flight");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		avg_valid |-> avg_data.frames_in_average <= N_W'(MAX_WINDOW))
		else $error("frame count out of range");

endmodule

bind frame_pixel_averager_core fpa_checker u_fpa_checker (.*);
`default_nettype wire

@@ tb/frame_pixel_averager_core_tb.sv @@
// frame_pixel_averager_core_tb: self-checking bench for the frame pixel averager core
// drives pixel transfers and register writes, predicts every averaged pixel in-bench
// depends on fpa_pkg and frame_pixel_averager_core
`timescale 1ns / 100ps
`default_nettype none
module frame_pixel_averager_core_tb;
	import fpa_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic pix_valid = 1'b0;
	logic pix_ready;
	pix_t pix_data = '0;
	logic avg_valid;
	logic avg_ready = 1'b0;
	avg_t avg_data;

	frame_pixel_averager_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix_data(pix_data),
		.avg_valid(avg_valid), .avg_ready(avg_ready), .avg_data(avg_data)
	);

	always #10 clk = ~clk;

	initial begin
		#200ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// shadow registers
	logic              sh_enable;
	logic              sh_mode;
	logic [N_W-1:0]    sh_window;
	logic [BASE_W-1:0] sh_base;
	logic [P_W-1:0]    sh_inv_b;

	// averaging state
	logic [ACC_W-1:0] acc_mem [MAX_PIXELS];
	logic [SMP_W-1:0] hist_mem [MAX_WINDOW*MAX_PIXELS];
	int unsigned pos;
	bit          beyond_end;
	int unsigned held, oldest, exp_count;
	logic [P_W-1:0] decay;
	bit          restart_pend;
	bit          f_on, f_restart, f_mode;
	int unsigned f_n;
	longint unsigned f_alpha;

	avg_t expected_q[$];
	int   mismatches = 0;
	int   sent = 0;
	int   send_idle_pct = 0, recv_idle_pct = 0;
	bit   recv_hold = 1'b0;

	function automatic longint unsigned blend_weight();
		longint unsigned b, p, num, den;
		b = 64'(sh_base);
		p = 64'(decay);
		num = (p >= (64'd1 << 24)) ? 0 : (64'd1 << 24) - p;
		den = (b > p) ? b - p : 0;
		if (den == 0 || num >= den)
			return 64'd1 << 24;
		return (num << 24) / den;
	endfunction

	function automatic void predict_reset();
		sh_enable = 1'b0; sh_mode = 1'b1; sh_window = RESET_N;
		sh_base = RESET_B; sh_inv_b = RESET_INV_B;
		pos = 0; beyond_end = 0; held = 0; oldest = 0; exp_count = 0;
		decay = ONE_Q24; restart_pend = 1;
		f_on = 0; f_restart = 0; f_mode = 0; f_n = 1; f_alpha = 0;
	endfunction

	function automatic void predict_write(int unsigned idx, logic [31:0] val);
		case (idx)
			REG_ENABLE: begin
				sh_enable = val[0];
				if (val[0]) restart_pend = 1;
			end
			REG_MODE: if (sh_mode != val[0]) begin
				sh_mode = val[0]; restart_pend = 1;
			end
			REG_WINDOW: if (sh_window != val[N_W-1:0]) begin
				sh_window = val[N_W-1:0]; restart_pend = 1;
			end
			REG_BASE: if (sh_base != val[BASE_W-1:0]) begin
				sh_base = val[BASE_W-1:0]; restart_pend = 1;
			end
			REG_INV_B: if (sh_inv_b != val[P_W-1:0]) begin
				sh_inv_b = val[P_W-1:0]; restart_pend = 1;
			end
			default: ;
		endcase
	endfunction

	function automatic avg_t predict_pixel(pix_t px);
		avg_t r;
		longint unsigned v, avg, cnt, h, slot, idx, old, drop, sum, dv, q, r8, mag, np;
		bit full;
		v = 64'(px.sample);
		avg = v << 8;
		cnt = 0;
		if (pos == 0 && !beyond_end) begin
			f_on = sh_enable;
			if (f_on) begin
				f_mode = sh_mode;
				f_n = (sh_window == 0) ? 1 : (sh_window > MAX_WINDOW ? MAX_WINDOW : sh_window);
				f_restart = restart_pend;
				restart_pend = 0;
				if (f_mode && !f_restart) f_alpha = blend_weight();
			end
		end
		if (f_on) begin
			if (!f_mode) begin
				h = f_restart ? 0 : 64'(held);
				full = h >= f_n;
				cnt = full ? 64'(f_n) : h + 1;
				if (!beyond_end) begin
					slot = (full ? 64'(oldest) : h) % MAX_WINDOW;
					idx = slot * MAX_PIXELS + pos;
					old = f_restart ? 0 : 64'(acc_mem[pos]);
					drop = full ? 64'(hist_mem[idx]) : 0;
					sum = (old + v >= drop) ? old + v - drop : 0;
					if (sum > 64'hFFFFFF) sum = 64'hFFFFFF;
					acc_mem[pos] = sum[23:0];
					hist_mem[idx] = v[15:0];
					dv = cnt;
					q = ((sum << 8) + dv / 2) / dv;
					avg = (q > 64'hFFFFFF) ? 64'hFFFFFF : q;
				end
			end else begin
				cnt = 64'(((f_restart ? 0 : exp_count) + 1) % f_n);
				if (!beyond_end) begin
					if (f_restart) begin
						acc_mem[pos] = avg[23:0];
					end else begin
						r8 = 64'(acc_mem[pos]);
						if (avg >= r8) begin
							mag = ((avg - r8) * f_alpha + (64'd1 << 23)) >> 24;
							avg = (r8 + mag) & 64'hFFFFFF;
						end else begin
							mag = ((r8 - avg) * f_alpha + (64'd1 << 23)) >> 24;
							avg = (r8 - mag) & 64'hFFFFFF;
						end
						acc_mem[pos] = avg[23:0];
					end
				end
			end
		end
		if (px.frame_end) begin
			if (f_on) begin
				if (!f_mode) begin
					if (f_restart) begin held = 0; oldest = 0; end
					if (held < f_n) held++;
					else oldest = (oldest + 1) % f_n;
				end else if (f_restart) begin
					exp_count = 1; decay = sh_inv_b;
				end else begin
					np = (longint'(decay) * sh_inv_b + (64'd1 << 23)) >> 24;
					exp_count++;
					decay = (np > 64'h1FFFFFF) ? 25'h1FFFFFF : np[24:0];
				end
			end
			pos = 0; beyond_end = 0;
		end else if (!beyond_end) begin
			pos++;
			if (pos >= MAX_PIXELS) begin pos = 0; beyond_end = 1; end
		end
		r.averaged = avg[23:0];
		r.frame_end_res = px.frame_end;
		r.frames_in_average = cnt[6:0];
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && avg_valid && avg_ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer %h", avg_data);
			end else begin
				avg_t e;
				e = expected_q[0];
				expected_q.delete(0);
				if (e.averaged !== avg_data.averaged || e.frame_end_res !== avg_data.frame_end_res
						|| e.frames_in_average !== avg_data.frames_in_average) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp avg=%h fe=%b n=%0d got avg=%h fe=%b n=%0d",
							e.averaged, e.frame_end_res, e.frames_in_average,
							avg_data.averaged, avg_data.frame_end_res,
							avg_data.frames_in_average);
				end
			end
		end
	end

	// result side ready
	always @(posedge clk) begin
		if (recv_hold)
			avg_ready <= 1'b0;
		else
			avg_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic reg_write(int unsigned idx, logic [31:0] val);
		pix_valid <= 1'b0;
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= PADDR_W'(idx * 4); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		predict_write(idx, val);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		pix_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic send_pixel(logic [15:0] s, logic fe, bit chk, logic [23:0] exp_avg);
		pix_t px;
		avg_t e;
		px.sample = s;
		px.frame_end = fe;
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_data <= px;
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
		e = predict_pixel(px);
		if (chk && e.averaged !== exp_avg) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row predicts %h, table says %h", e.averaged, exp_avg);
		end
		expected_q.insert(expected_q.size(), e);
		sent++;
	endtask

	// frame of given length; content drawn from a mix of extremes and random values
	task automatic send_frame(int unsigned len);
		logic [15:0] s;
		for (int unsigned i = 0; i < len; i++) begin
			case ($urandom_range(5))
				0: s = 16'h0000;
				1: s = 16'hFFFF;
				default: s = 16'($urandom);
			endcase
			send_pixel(s, i == len - 1, 0, '0);
		end
	endtask

	typedef struct {
		logic [15:0] s;
		logic        fe;
		bit          chk;
		logic [23:0] avg;
	} row_t;

	row_t rows[$] = '{
		'{16'h0000, 1'b0, 1, 24'h000000},
		'{16'hFFFF, 1'b0, 1, 24'hFFFF00},
		'{16'h8001, 1'b1, 1, 24'h800100},
		'{16'h1234, 1'b1, 1, 24'h123400}
	};

	int unsigned frame_len;
	int unsigned window_pick;
	logic [31:0] cfg_val;

	initial begin
		predict_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pass-through rows after reset
		foreach (rows[i]) send_pixel(rows[i].s, rows[i].fe, rows[i].chk, rows[i].avg);
		wait_drained();

		// directed: window mode, N=2, extremes
		reg_write(REG_MODE, 0);
		reg_write(REG_WINDOW, 2);
		reg_write(REG_ENABLE, 1);
		for (int f = 0; f < 4; f++) begin
			send_pixel(16'hFFFF, 0, 0, '0);
			send_pixel(16'h0000, 0, 0, '0);
			send_pixel(16'(f * 16'h3333), 1, 0, '0);
		end
		wait_drained();
		// exponential mode with first frame copy, N=1 and N=0 clamp
		reg_write(REG_MODE, 1);
		for (int f = 0; f < 3; f++) begin
			send_pixel(16'(f * 16'h7FFF), 0, 0, '0);
			send_pixel(16'hFFFF - 16'(f), 1, 0, '0);
		end
		wait_drained();
		reg_write(REG_WINDOW, 0);
		reg_write(REG_BASE, 32'h2FFFFFF);
		reg_write(REG_INV_B, 32'h0);
		send_frame(2);
		send_frame(2);
		wait_drained();
		// large window clamp
		reg_write(REG_WINDOW, 127);
		reg_write(REG_INV_B, 32'h1000000);
		reg_write(REG_BASE, 32'h1000000);
		send_frame(4);
		send_frame(4);
		wait_drained();

		// random phases
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 76 : 0;
			recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 33 : 0;
			for (int cfg = 0; cfg < 4; cfg++) begin
				wait_drained();
				case ($urandom_range(3))
					0: window_pick = 1;
					1: window_pick = 64;
					default: window_pick = $urandom_range(1, 6);
				endcase
				reg_write(REG_MODE, $urandom_range(1));
				reg_write(REG_WINDOW, window_pick);
				if ($urandom_range(1)) begin
					reg_write(REG_BASE, 17116135);
					reg_write(REG_INV_B, 16445002);
				end else begin
					cfg_val = $urandom_range(32'h1000000, 32'h2FFFFFF);
					reg_write(REG_BASE, cfg_val);
					reg_write(REG_INV_B, $urandom_range(0, 32'h1000000));
				end
				reg_write(REG_ENABLE, 32'($urandom_range(4) != 0));
				frame_len = $urandom_range(1, 14);
				for (int f = 0; f < 8; f++) begin
					send_frame(frame_len);
					if (phase == 2 && cfg == 1 && f == 2) begin
						recv_hold = 1'b1;
						fork
							begin
								repeat (300) @(posedge clk);
								recv_hold = 1'b0;
							end
						join_none
					end
				end
			end
		end
		recv_hold = 1'b0;

		// drain
		pix_valid <= 1'b0;
		fork
			begin
				while (expected_q.size() != 0) @(posedge clk);
				repeat (80) @(posedge clk);
			end
			begin
				repeat (200000) @(posedge clk);
				mismatches++;
			end
		join_any
		if (mismatches == 0 && expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
